// ===== rtl/ifbc_pkg.sv =====
package ifbc_pkg;

   // frame layout: seven big-endian words, bytes 0..12 buffered, byte 13 closes the frame
   localparam int FRAME_LAST_POS = 13;
   localparam int NUM_WORDS      = 7;
   localparam int NUM_AXES       = 6;
   localparam int WORD_W         = 16;
   localparam int BYTE_W         = 8;
   localparam int POS_W          = 4;
   localparam int AXIS_W         = 3;

   // calibration run
   localparam int SUM_W       = 24;
   localparam int FCNT_W      = 9;
   localparam int SKIP_FRAMES = 50;
   localparam int RUN_FRAMES  = 300;
   localparam int AVG_FRAMES  = 250;

   // divide by 250 as multiply by floor(2^32 / 250) plus one correction step
   localparam int RECIP_W     = 25;
   localparam int RECIP_SHIFT = 32;
   localparam int QUOT_W      = 16;
   localparam logic [RECIP_W-1:0] AVG_RECIP = 25'd17179869;

   // tuser bit positions on the request side
   localparam int USER_MODE_BIT  = 0;
   localparam int USER_FIRST_BIT = 1;

   typedef enum logic {
      CMD_FRAME = 1'b0,
      CMD_START = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                     kind;
      logic [NUM_WORDS-1:0][WORD_W-1:0] words;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic applied;
   } rsp_user_type;

   typedef logic [NUM_AXES-1:0][SUM_W-1:0]  sums_type;
   typedef logic [NUM_AXES-1:0][WORD_W-1:0] biases_type;

   typedef struct packed {
      logic              busy;
      logic              wr_valid;
      logic [AXIS_W-1:0] wr_idx;
      logic [WORD_W-1:0] wr_bias;
   } div_status_type;

   // motion axis to word slot: temperature sits in slot 3
   function automatic logic [AXIS_W-1:0] axis_word(input logic [AXIS_W-1:0] axis);
      logic [AXIS_W-1:0] slot;
      slot = (axis < AXIS_W'(3)) ? axis : axis + AXIS_W'(1);
      return slot;
   endfunction

endpackage

// ===== rtl/ifbc_front.sv =====
module ifbc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic [1:0]           req_tuser,
   output logic                 push_valid,
   output ifbc_pkg::cmd_type    push_cmd,
   input  logic                 queue_full
);

   logic [ifbc_pkg::POS_W-1:0]  pos_ff, pos_in, pos_eff;
   logic [ifbc_pkg::BYTE_W-1:0] frame_bytes_ff [ifbc_pkg::FRAME_LAST_POS];
   logic [ifbc_pkg::BYTE_W-1:0] frame_bytes_in [ifbc_pkg::FRAME_LAST_POS];
   logic                        accept, is_start, frame_end;

   always_comb begin
      req_tready = !queue_full;
      accept     = req_tvalid && req_tready;
      is_start   = req_tuser[ifbc_pkg::USER_MODE_BIT];
      pos_eff    = req_tuser[ifbc_pkg::USER_FIRST_BIT] ? '0 : pos_ff;
      frame_end  = (pos_eff >= ifbc_pkg::POS_W'(ifbc_pkg::FRAME_LAST_POS));

      pos_in         = pos_ff;
      frame_bytes_in = frame_bytes_ff;
      if (accept && !is_start) begin
         if (frame_end) begin
            pos_in = '0;
         end else begin
            frame_bytes_in[pos_eff] = req_tdata;
            pos_in                  = pos_eff + 1'b1;
         end
      end

      push_valid    = accept && (is_start || frame_end);
      push_cmd.kind = is_start ? ifbc_pkg::CMD_START : ifbc_pkg::CMD_FRAME;
      for (int w = 0; w < ifbc_pkg::NUM_WORDS - 1; w++) begin
         push_cmd.words[w] = {frame_bytes_ff[2*w], frame_bytes_ff[2*w+1]};
      end
      push_cmd.words[ifbc_pkg::NUM_WORDS-1] =
         {frame_bytes_ff[ifbc_pkg::FRAME_LAST_POS-1], req_tdata};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_bytes_ff <= frame_bytes_in;
   end

endmodule

// ===== rtl/ifbc_fifo.sv =====
module ifbc_fifo #(
   parameter int WIDTH = 113,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] mem_in [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full      = (count_ff == CNT_W'(DEPTH));
      pop_valid = (count_ff != '0);
      pop_data  = mem_ff[rd_ptr_ff];
      do_push   = push_valid && !full;
      do_pop    = pop && pop_valid;

      mem_in    = mem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         mem_in[wr_ptr_ff] = push_data;
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
   end

endmodule

// ===== rtl/ifbc_div.sv =====
module ifbc_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  ifbc_pkg::sums_type       sums,
   output ifbc_pkg::div_status_type status
);

   localparam int PROD_W = ifbc_pkg::SUM_W + ifbc_pkg::RECIP_W;

   logic                          issuing_ff, issuing_in;
   logic [ifbc_pkg::AXIS_W-1:0]   idx_ff, idx_in;
   logic                          v1_ff, v1_in, v2_ff, v2_in;
   logic [ifbc_pkg::AXIS_W-1:0]   tag1_ff, tag1_in, tag2_ff, tag2_in;
   logic [ifbc_pkg::SUM_W-1:0]    mag1_ff, mag1_in, mag2_ff, mag2_in;
   logic                          neg1_ff, neg1_in, neg2_ff, neg2_in;
   logic [ifbc_pkg::QUOT_W-1:0]   quot2_ff, quot2_in;
   logic [ifbc_pkg::SUM_W-1:0]    sel, rem;
   logic [PROD_W-1:0]             prod;
   logic [ifbc_pkg::QUOT_W-1:0]   quot_fix;

   always_comb begin
      // issue: pick one axis sum a cycle and take its magnitude
      sel     = sums[idx_ff];
      neg1_in = sel[ifbc_pkg::SUM_W-1];
      mag1_in = neg1_in ? (~sel + 1'b1) : sel;
      tag1_in = idx_ff;
      v1_in   = issuing_ff;

      issuing_in = issuing_ff;
      idx_in     = idx_ff;
      if (start) begin
         issuing_in = 1'b1;
         idx_in     = '0;
      end else if (issuing_ff) begin
         if (idx_ff == ifbc_pkg::AXIS_W'(ifbc_pkg::NUM_AXES - 1)) begin
            issuing_in = 1'b0;
         end
         idx_in = idx_ff + 1'b1;
      end

      // reciprocal multiply, quotient low by at most one
      prod     = PROD_W'(mag1_ff) * PROD_W'(ifbc_pkg::AVG_RECIP);
      quot2_in = prod[ifbc_pkg::RECIP_SHIFT +: ifbc_pkg::QUOT_W];
      mag2_in  = mag1_ff;
      neg2_in  = neg1_ff;
      tag2_in  = tag1_ff;
      v2_in    = v1_ff;

      // correction and sign restore, truncation toward zero
      rem      = mag2_ff - ifbc_pkg::SUM_W'(quot2_ff) *
                 ifbc_pkg::SUM_W'(ifbc_pkg::AVG_FRAMES);
      quot_fix = quot2_ff +
                 ifbc_pkg::QUOT_W'(rem >= ifbc_pkg::SUM_W'(ifbc_pkg::AVG_FRAMES));

      status.busy     = issuing_ff || v1_ff || v2_ff;
      status.wr_valid = v2_ff;
      status.wr_idx   = tag2_ff;
      status.wr_bias  = neg2_ff ? (~quot_fix + 1'b1) : quot_fix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
         idx_ff     <= '0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
      end else begin
         issuing_ff <= issuing_in;
         idx_ff     <= idx_in;
         v1_ff      <= v1_in;
         v2_ff      <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      tag1_ff  <= tag1_in;
      mag1_ff  <= mag1_in;
      neg1_ff  <= neg1_in;
      tag2_ff  <= tag2_in;
      mag2_ff  <= mag2_in;
      neg2_ff  <= neg2_in;
      quot2_ff <= quot2_in;
   end

endmodule

// ===== rtl/ifbc_back.sv =====
module ifbc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  ifbc_pkg::cmd_type        cmd,
   output logic                     cmd_pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [111:0]             rsp_tdata,
   output logic [1:0]               rsp_tuser,
   output logic                     div_start,
   output ifbc_pkg::sums_type       sums,
   input  ifbc_pkg::div_status_type div_status
);

   logic                          calibrating_ff, calibrating_in;
   logic                          calibrated_ff, calibrated_in;
   logic [ifbc_pkg::FCNT_W-1:0]   fcnt_ff, fcnt_in, fcnt_next;
   ifbc_pkg::sums_type            sums_ff, sums_in;
   ifbc_pkg::biases_type          biases_ff, biases_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ifbc_pkg::NUM_WORDS-1:0][ifbc_pkg::WORD_W-1:0] rsp_data_ff, rsp_data_in;
   ifbc_pkg::rsp_user_type        rsp_user_ff, rsp_user_in;
   logic                          out_free, pop_frame, run_end;
   logic [ifbc_pkg::WORD_W-1:0]   word;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_tready;
      cmd_pop   = cmd_valid && !div_status.busy &&
                  (cmd.kind == ifbc_pkg::CMD_START || out_free);
      pop_frame = cmd_pop && (cmd.kind == ifbc_pkg::CMD_FRAME);
      fcnt_next = fcnt_ff + 1'b1;
      run_end   = calibrating_ff && (fcnt_next == ifbc_pkg::FCNT_W'(ifbc_pkg::RUN_FRAMES));
      div_start = pop_frame && run_end;
      word      = '0;

      calibrating_in = calibrating_ff;
      calibrated_in  = calibrated_ff;
      fcnt_in        = fcnt_ff;
      sums_in        = sums_ff;
      biases_in      = biases_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;

      if (cmd_pop && cmd.kind == ifbc_pkg::CMD_START) begin
         calibrating_in = 1'b1;
         fcnt_in        = '0;
         sums_in        = '0;
      end

      if (pop_frame) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = cmd.words;
         rsp_user_in  = '0;
         if (calibrating_ff) begin
            fcnt_in = fcnt_next;
            if (fcnt_next > ifbc_pkg::FCNT_W'(ifbc_pkg::SKIP_FRAMES)) begin
               for (int a = 0; a < ifbc_pkg::NUM_AXES; a++) begin
                  word       = cmd.words[ifbc_pkg::axis_word(ifbc_pkg::AXIS_W'(a))];
                  sums_in[a] = sums_ff[a] +
                               {{(ifbc_pkg::SUM_W - ifbc_pkg::WORD_W){word[ifbc_pkg::WORD_W-1]}},
                                word};
               end
            end
            if (run_end) begin
               calibrated_in    = 1'b1;
               calibrating_in   = 1'b0;
               rsp_user_in.done = 1'b1;
            end
         end else if (calibrated_ff) begin
            for (int a = 0; a < ifbc_pkg::NUM_AXES; a++) begin
               rsp_data_in[ifbc_pkg::axis_word(ifbc_pkg::AXIS_W'(a))] =
                  cmd.words[ifbc_pkg::axis_word(ifbc_pkg::AXIS_W'(a))] - biases_ff[a];
            end
            rsp_user_in.applied = 1'b1;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (div_status.wr_valid) begin
         biases_in[div_status.wr_idx] = div_status.wr_bias;
      end

      sums       = sums_ff;
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = rsp_data_ff;
      rsp_tuser  = rsp_user_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calibrating_ff <= 1'b0;
         calibrated_ff  <= 1'b0;
         fcnt_ff        <= '0;
         sums_ff        <= '0;
         biases_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         calibrating_ff <= calibrating_in;
         calibrated_ff  <= calibrated_in;
         fcnt_ff        <= fcnt_in;
         sums_ff        <= sums_in;
         biases_ff      <= biases_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // the completing frame goes out raw
   a_done_not_applied: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_user_ff.applied && rsp_user_ff.done))
      else $error("completing frame marked as bias corrected");

   a_fcnt_in_run: assert property (@(posedge clock) disable iff (reset)
      calibrating_ff |-> (fcnt_ff < ifbc_pkg::FCNT_W'(ifbc_pkg::RUN_FRAMES)))
      else $error("frame counter ran past the end of the run");

   a_div_follows_end: assert property (@(posedge clock) disable iff (reset)
      div_start |=> div_status.busy)
      else $error("divider idle after run end");

   a_bias_write_calibrated: assert property (@(posedge clock) disable iff (reset)
      div_status.wr_valid |-> (calibrated_ff && !calibrating_ff))
      else $error("bias written outside a completed run");

endmodule

// ===== rtl/imu_frame_bias_calibrator_core.sv =====
// result path: a frame's last byte pushes it into the queue, then the back end pops it into the output register
// throughput: one byte per cycle while the queue is not full; one result per 14-byte frame
// end of a calibration run: the back end holds off while the divider works the six divisions by 250,
// one axis per cycle through a 3-stage reciprocal divider; the queue absorbs this
// reset: synchronous, clears byte position, run state, sums, biases, queue and output

module imu_frame_bias_calibrator_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic [1:0]   req_tuser,   // mode, frame_first
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // accel_x, accel_y, accel_z, temperature, gyro_x, gyro_y, gyro_z
   output logic [1:0]   rsp_tuser    // bias_applied, calibration_done
);

   localparam int CMD_W = $bits(ifbc_pkg::cmd_type);

   // front to queue
   logic                     push_valid;
   ifbc_pkg::cmd_type        push_cmd;
   logic                     queue_full;

   // queue to back
   logic                     cmd_valid;
   logic                     cmd_pop;
   logic [CMD_W-1:0]         cmd_bits;
   ifbc_pkg::cmd_type        cmd;

   // back to divider
   logic                     div_start;
   ifbc_pkg::sums_type       sums;
   ifbc_pkg::div_status_type div_status;

   assign cmd = cmd_bits;

   // byte assembly and item classification
   ifbc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   // decouples frame assembly from calibration and output stalls
   ifbc_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_cmd),
      .full       (queue_full),
      .pop        (cmd_pop),
      .pop_valid  (cmd_valid),
      .pop_data   (cmd_bits)
   );

   // run control, summing, bias subtraction and output register
   ifbc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .div_start  (div_start),
      .sums       (sums),
      .div_status (div_status)
   );

   // bias = sum / 250 toward zero, one axis per cycle
   ifbc_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .sums   (sums),
      .status (div_status)
   );

endmodule

// ===== tb/imu_sample_checker.sv =====
module imu_sample_checker
   import ifbc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic [1:0]   req_tuser,   // mode, frame_first
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [111:0] rsp_tdata,   // accel_x, accel_y, accel_z, temperature, gyro_x, gyro_y, gyro_z
   input  logic [1:0]   rsp_tuser,   // bias_applied, calibration_done
   output int           mismatch_count,
   output int           samples_waiting,
   output int           sample_count,
   output int           corrected_count,
   output int           runs_completed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TEMP_SLOT    = 3;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic                             done;
      logic                             applied;
      logic [NUM_WORDS-1:0][WORD_W-1:0] words;
   } imu_sample_type;

   // shadow of the block state
   logic [POS_W-1:0]         fill_pos;
   logic [BYTE_W-1:0]        held_bytes [FRAME_LAST_POS];
   logic                     run_active;
   logic                     have_bias;
   logic [FCNT_W-1:0]        run_frames;
   logic signed [SUM_W-1:0]  axis_sum  [NUM_AXES];
   logic signed [WORD_W-1:0] axis_bias [NUM_AXES];

   imu_sample_type expected_samples [$];
   int failures, samples, corrected, runs;

   task automatic absorb_transfer(input logic [1:0] user, input logic [BYTE_W-1:0] data_in);
      logic [BYTE_W-1:0]        burst [FRAME_LAST_POS+1];
      logic signed [WORD_W-1:0] axis_word;
      imu_sample_type           s;
      int                       slot;
      if (cmd_kind_type'(user[USER_MODE_BIT]) == CMD_START) begin
         // run restarts, byte position and biases untouched
         run_active = 1'b1;
         run_frames = '0;
         foreach (axis_sum[a]) axis_sum[a] = '0;
         return;
      end
      if (user[USER_FIRST_BIT]) fill_pos = '0;
      if (fill_pos < FRAME_LAST_POS) begin
         held_bytes[fill_pos] = data_in;
         fill_pos = fill_pos + 1'b1;
         return;
      end
      fill_pos = '0;
      foreach (held_bytes[i]) burst[i] = held_bytes[i];
      burst[FRAME_LAST_POS] = data_in;
      s = '0;
      for (int w = 0; w < NUM_WORDS; w++) begin
         s.words[w] = {burst[2*w], burst[2*w+1]};
      end
      if (run_active) begin
         run_frames = run_frames + 1'b1;
         for (int a = 0; a < NUM_AXES; a++) begin
            slot = (a < TEMP_SLOT) ? a : a + 1;
            axis_word = s.words[slot];
            if (run_frames > SKIP_FRAMES) axis_sum[a] = axis_sum[a] + axis_word;
         end
         if (run_frames == RUN_FRAMES) begin
            // signed division truncates toward zero
            foreach (axis_bias[a]) axis_bias[a] = WORD_W'(axis_sum[a] / AVG_FRAMES);
            have_bias  = 1'b1;
            run_active = 1'b0;
            s.done     = 1'b1;
         end
      end else if (have_bias) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            slot = (a < TEMP_SLOT) ? a : a + 1;
            s.words[slot] = s.words[slot] - axis_bias[a];
         end
         s.applied = 1'b1;
      end
      expected_samples.push_back(s);
   endtask

   task automatic report_field(input string field, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
      failures++;
      if (failures <= REPORT_LIMIT)
         $display("%0d ns: mismatch on %s, expected %h, got %h", $time, field, want, got);
   endtask

   task automatic check_sample(input logic [111:0] data, input logic [1:0] user);
      rsp_user_type   flags;
      imu_sample_type got, want;
      flags       = user;
      got.words   = data;
      got.applied = flags.applied;
      got.done    = flags.done;
      samples++;
      if (got.applied) corrected++;
      if (got.done) runs++;
      if (expected_samples.size() == 0) begin
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("%0d ns: sample with none expected: %h", $time, got);
         return;
      end
      want = expected_samples.pop_front();
      for (int w = 0; w < NUM_WORDS; w++) begin
         if (got.words[w] !== want.words[w])
            report_field($sformatf("word %0d", w), want.words[w], got.words[w]);
      end
      if (got.applied !== want.applied) report_field("bias_applied", want.applied, got.applied);
      if (got.done !== want.done) report_field("calibration_done", want.done, got.done);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fill_pos   = '0;
         run_active = 1'b0;
         have_bias  = 1'b0;
         run_frames = '0;
         foreach (held_bytes[i]) held_bytes[i] = '0;
         foreach (axis_sum[a]) axis_sum[a] = '0;
         foreach (axis_bias[a]) axis_bias[a] = '0;
         expected_samples.delete();
         failures  = 0;
         samples   = 0;
         corrected = 0;
         runs      = 0;
      end else begin
         if (req_tvalid && req_tready) absorb_transfer(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) check_sample(rsp_tdata, rsp_tuser);
      end
      mismatch_count  <= failures;
      samples_waiting <= expected_samples.size();
      sample_count    <= samples;
      corrected_count <= corrected;
      runs_completed  <= runs;
   end

endmodule

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ifbc_pkg::*;

   // word slot that carries temperature, never corrected
   localparam int TEMP_SLOT = 3;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = '0;   // data_byte
   logic [1:0]   req_tuser  = '0;   // mode, frame_first
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;         // accel_x, accel_y, accel_z, temperature, gyro_x, gyro_y, gyro_z
   logic [1:0]   rsp_tuser;         // bias_applied, calibration_done

   int mismatch_count, samples_waiting, sample_count, corrected_count, runs_completed;

   // idle rates in percent, changed per phase
   int sender_idle_pct   = 22;
   int receiver_idle_pct = 64;

   // sensor model for generated frames: per-axis offset, noise spread, share of wild words
   logic [WORD_W-1:0] axis_base [NUM_AXES];
   int                axis_spread = 0;
   int                wild_pct    = 100;

   // set after a truncated burst so the next frame carries a first mark
   bit need_mark = 1'b0;
   int transfer_count = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   imu_frame_bias_calibrator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   imu_sample_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .mismatch_count  (mismatch_count),
      .samples_waiting (samples_waiting),
      .sample_count    (sample_count),
      .corrected_count (corrected_count),
      .runs_completed  (runs_completed)
   );

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(1, 100) > receiver_idle_pct);
   end

   // one request transfer, with random idle cycles in front of it
   task automatic send_item(input cmd_kind_type kind, input logic [7:0] data_in,
                            input logic first);
      logic [1:0] user;
      while ($urandom_range(1, 100) <= sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      user                 = '0;
      user[USER_MODE_BIT]  = kind;
      user[USER_FIRST_BIT] = first;
      req_tvalid <= 1'b1;
      req_tdata  <= data_in;
      req_tuser  <= user;
      do @(posedge clock); while (!req_tready);
      transfer_count++;
   endtask

   // 14-byte burst, big-endian words; a start item may be slipped in before byte start_at
   task automatic send_frame_bytes(input logic [NUM_WORDS-1:0][WORD_W-1:0] words,
                                   input bit marked, input int start_at);
      for (int i = 0; i <= FRAME_LAST_POS; i++) begin
         if (i == start_at) send_item(CMD_START, 8'($urandom), 1'($urandom));
         send_item(CMD_FRAME, 8'(words[i / 2] >> ((i % 2 == 0) ? 8 : 0)), marked && (i == 0));
      end
   endtask

   function automatic logic [WORD_W-1:0] sensor_word(input int axis);
      logic [WORD_W-1:0] noise;
      if ($urandom_range(1, 100) <= wild_pct) return WORD_W'($urandom);
      noise = WORD_W'($urandom_range(0, 2 * axis_spread));
      return axis_base[axis] + noise - WORD_W'(axis_spread);
   endfunction

   // one complete frame, sometimes preceded by a truncated burst, sometimes unmarked
   task automatic send_sample(input int start_at);
      logic [NUM_WORDS-1:0][WORD_W-1:0] words;
      bit                               marked;
      int                               chunk;
      if ($urandom_range(1, 100) <= 8) begin
         // broken burst, resynchronized by the next first mark
         chunk = $urandom_range(1, FRAME_LAST_POS);
         for (int i = 0; i < chunk; i++) send_item(CMD_FRAME, 8'($urandom), i == 0);
         need_mark = 1'b1;
      end
      // an unmarked frame only when the byte position is known to be zero
      marked    = need_mark || ($urandom_range(1, 100) <= 88);
      need_mark = 1'b0;
      for (int w = 0; w < NUM_WORDS; w++) begin
         words[w] = (w == TEMP_SLOT) ? WORD_W'($urandom)
                                     : sensor_word((w < TEMP_SLOT) ? w : w - 1);
      end
      send_frame_bytes(words, marked, start_at);
   endtask

   initial begin
      logic [NUM_WORDS-1:0][WORD_W-1:0] edge_words;
      int spread_pick;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: word extremes, a start item in the middle of a frame (position kept),
      // then a burst cut short and resynchronized
      edge_words = {16'h8001, 16'hFF7F, 16'h0080, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000};
      send_frame_bytes(edge_words, 1'b1, 5);
      send_item(CMD_FRAME, 8'hFF, 1'b1);
      send_item(CMD_FRAME, 8'h00, 1'b0);
      send_item(CMD_FRAME, 8'h80, 1'b0);
      need_mark = 1'b1;

      // three idle regimes, each with a run started inside a frame and restarted between frames
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               sender_idle_pct   = 22;
               receiver_idle_pct = 64;
            end
            1: begin
               sender_idle_pct   = 64;
               receiver_idle_pct = 22;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase

         wild_pct = 100;
         repeat (10) send_sample(-1);

         if (p == 0) begin
            // constant full-scale axes
            foreach (axis_base[a]) axis_base[a] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            axis_spread = 0;
            wild_pct    = 0;
         end else begin
            foreach (axis_base[a]) axis_base[a] = WORD_W'($urandom);
            spread_pick = $urandom_range(0, 2);
            axis_spread = (spread_pick == 0) ? 0 : (spread_pick == 1) ? 100 : 3000;
            wild_pct    = 4;
         end

         // run begins inside this frame, so it counts as the run's first
         send_sample($urandom_range(0, FRAME_LAST_POS));
         repeat (8) send_sample(-1);

         // restart between frames, frames keep going out raw
         send_item(CMD_START, 8'($urandom), 1'($urandom));
         wild_pct = 100;
         repeat (9) send_sample(-1);
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (samples_waiting != 0) @(posedge clock);
      // results trail the last transfer through the queue and the output register
      repeat (20) @(posedge clock);

      $display("%0d transfers sent, %0d frame results checked, %0d with bias removed",
               transfer_count, sample_count, corrected_count);
      $display("%0d runs finished; starts sent mid-frame and between frames in three idle regimes",
               runs_completed);
      if (mismatch_count == 0 && samples_waiting == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
